FILE: sv/tt800_pkg.sv
// Package for the TT800 random generator: sizes, constants, the reset seed table
// and the twist and temper functions. Depends on nothing.
`default_nettype none

package tt800_pkg;

	localparam int STATE_WORDS = 25;
	localparam int TAP_OFFSET  = 7;
	localparam int AW          = $clog2(STATE_WORDS);
	localparam int WORD_W      = 32;

	localparam logic [WORD_W-1:0] MAG_VECTOR = 32'h8ebf_d028;
	localparam logic [WORD_W-1:0] TEMPER_B   = 32'h2b5b_2500;
	localparam logic [WORD_W-1:0] TEMPER_C   = 32'hdb8b_0000;
	localparam logic [WORD_W-1:0] SEED_MULT  = 32'd69069;

	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_SEED = 1'b1;

	localparam logic [WORD_W-1:0] RESET_TABLE [STATE_WORDS] = '{
		32'h95f24dab, 32'h0b685215, 32'he76ccae7, 32'haf3ec239, 32'h715fad23,
		32'h24a590ad, 32'h69e4b5ef, 32'hbf456141, 32'h96bc1b7b, 32'ha7bdf825,
		32'hc1de75b7, 32'h8858a9c9, 32'h2da87693, 32'hb657f9dd, 32'hffdc8a9f,
		32'h8121da71, 32'h8b823ecb, 32'h885d05f5, 32'h4e20cd47, 32'h5a9ad5d9,
		32'h512c0c03, 32'hea857ccd, 32'h4cc1d30f, 32'h8891a8a1, 32'ha6b7aadb
	};

	// Partner word of the twist: (i + TAP_OFFSET) mod STATE_WORDS.
	function automatic logic [AW-1:0] tap_index(input logic [AW-1:0] i);
		logic [AW:0] s;
		s = {1'b0, i} + (AW+1)'(TAP_OFFSET);
		if (s >= (AW+1)'(STATE_WORDS)) begin
			s = s - (AW+1)'(STATE_WORDS);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] w);
		return (w >> 1) ^ (w[0] ? MAG_VECTOR : '0);
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] t;
		t = w ^ ((w << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 16);
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: sv/tt800_ifs.sv
// Handshake channels of the TT800 generator: command channel and word channel.
// Depends on nothing.
`default_nettype none

interface tt800_cmd_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] seed_value;

	modport source (output valid, cmd, seed_value, input ready);
	modport sink   (input valid, cmd, seed_value, output ready);
endinterface

interface tt800_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;

	modport source (output valid, random_word, input ready);
	modport sink   (input valid, random_word, output ready);
endinterface

`default_nettype wire

FILE: sv/tt800_random_generator.sv
// Top level of the TT800 twisted GFSR generator: control, valid bits and output register.
// Depends on tt800_pkg, tt800_ifs (channels) and tt800_ram (word store).
//
//   Channel  Dir  Payload                     Transfer
//   req      in   cmd (1), seed_value (32)    req.valid && req.ready
//   rsp      out  random_word (32)            rsp.valid && rsp.ready
//
// In a draw the command is taken and the word store is read, then the read word is
// tempered into the output register once that register is free. A draw that finds all
// words used first runs the twist, one word per cycle through the store's two read ports.
// A reseed writes one word per cycle through the seed multiplier.
// After reset the store reads as the built-in seed table through per-word valid bits,
// so no clearing pass is needed. A stalled output holds its word; the block still
// takes the next command and waits only when a new word has to go out.
`default_nettype none

module tt800_random_generator
	import tt800_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	tt800_cmd_if.sink    req,
	tt800_word_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEED,
		S_TWIST,
		S_DRAW
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      pos_q;       // next word to draw; STATE_WORDS means used up
	logic [AW:0]        pos_cnt_q;   // holds 0..STATE_WORDS
	logic [AW-1:0]      idx_q;       // seed write index
	logic [AW:0]        tw_cnt_q;    // twist reads issued, 0..STATE_WORDS
	logic [WORD_W-1:0]  seed_q;      // current seed word, next product registered here
	logic               tw_v_s1;
	logic [AW-1:0]      tw_idx_s1;
	logic [STATE_WORDS-1:0] written_q;
	logic               vld_a_s1;
	logic               vld_b_s1;
	logic [AW-1:0]      addr_a_s1;
	logic [AW-1:0]      addr_b_s1;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_word_q;

	logic               re;
	logic [AW-1:0]      raddr_a;
	logic [AW-1:0]      raddr_b;
	logic [WORD_W-1:0]  rdata_a;
	logic [WORD_W-1:0]  rdata_b;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [WORD_W-1:0]  wdata;
	logic [WORD_W-1:0]  word_a;
	logic [WORD_W-1:0]  word_b;
	logic               out_free;
	logic               req_fire;
	logic               twist_last;

	assign pos_q = pos_cnt_q[AW-1:0];

	// A word that was never written since reset still holds its seed table value.
	assign word_a = vld_a_s1 ? rdata_a : RESET_TABLE[addr_a_s1];
	assign word_b = vld_b_s1 ? rdata_b : RESET_TABLE[addr_b_s1];

	assign out_free   = !out_valid_q || rsp.ready;
	assign req_fire   = req.valid && req.ready;
	assign twist_last = tw_v_s1 && (tw_idx_s1 == AW'(STATE_WORDS - 1));

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.random_word = out_word_q;

	// Read and write port control. The twist reads word i and its partner while the
	// previous word is written back; the two never address the same entry, and the
	// partners at or past the wrap were rewritten many cycles earlier.
	always_comb begin
		re      = 1'b0;
		raddr_a = pos_q;
		raddr_b = tap_index(pos_q);
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = seed_q;
		unique case (state_q)
			S_IDLE: begin
				re = req_fire && (req.cmd == CMD_DRAW)
					&& (pos_cnt_q < (AW+1)'(STATE_WORDS));
			end
			S_SEED: begin
				we = 1'b1;
			end
			S_TWIST: begin
				if (tw_cnt_q < (AW+1)'(STATE_WORDS)) begin
					re      = 1'b1;
					raddr_a = tw_cnt_q[AW-1:0];
					raddr_b = tap_index(tw_cnt_q[AW-1:0]);
				end else if (twist_last) begin
					// The first draw after the twist reads word 0.
					re      = 1'b1;
					raddr_a = '0;
					raddr_b = tap_index('0);
				end
				we    = tw_v_s1;
				waddr = tw_idx_s1;
				wdata = word_b ^ twist(word_a);
			end
			S_DRAW: begin
			end
			default: begin
			end
		endcase
	end

	tt800_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STATE_WORDS),
		.AW    (AW)
	) u_words (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Valid bits of the word store and the read-side pipeline registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			vld_a_s1  <= 1'b0;
			vld_b_s1  <= 1'b0;
			addr_a_s1 <= '0;
			addr_b_s1 <= '0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_a_s1  <= written_q[raddr_a];
				vld_b_s1  <= written_q[raddr_b];
				addr_a_s1 <= raddr_a;
				addr_b_s1 <= raddr_b;
			end
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_cnt_q   <= '0;
			idx_q       <= '0;
			tw_cnt_q    <= '0;
			seed_q      <= '0;
			tw_v_s1     <= 1'b0;
			tw_idx_s1   <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			// In the draw state the output register is refilled below instead.
			if (out_valid_q && rsp.ready && (state_q != S_DRAW)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.cmd == CMD_SEED) begin
							seed_q  <= req.seed_value;
							idx_q   <= '0;
							state_q <= S_SEED;
						end else if (pos_cnt_q >= (AW+1)'(STATE_WORDS)) begin
							tw_cnt_q <= '0;
							tw_v_s1  <= 1'b0;
							state_q  <= S_TWIST;
						end else begin
							state_q <= S_DRAW;
						end
					end
				end
				S_SEED: begin
					// Each product is registered before it feeds the next multiply.
					seed_q <= WORD_W'(seed_q * SEED_MULT);
					idx_q  <= idx_q + AW'(1);
					if (idx_q == AW'(STATE_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_TWIST: begin
					if (tw_cnt_q < (AW+1)'(STATE_WORDS)) begin
						tw_v_s1   <= 1'b1;
						tw_idx_s1 <= tw_cnt_q[AW-1:0];
						tw_cnt_q  <= tw_cnt_q + (AW+1)'(1);
					end else begin
						tw_v_s1 <= 1'b0;
					end
					if (twist_last) begin
						pos_cnt_q <= '0;
						state_q   <= S_DRAW;
					end
				end
				S_DRAW: begin
					// The read data holds while the output register is still full.
					if (out_free) begin
						out_word_q  <= temper(word_a);
						out_valid_q <= 1'b1;
						pos_cnt_q   <= pos_cnt_q + (AW+1)'(1);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/tt800_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Depends on nothing.
`default_nettype none

module tt800_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 25,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for tt800_random_generator: drives draw and reseed commands
// through the request channel and checks every tempered word on the response channel.
// Depends on tt800_pkg and the channel interfaces in tt800_ifs.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tt800_pkg::*;

	// Number of random commands after the directed opening.
	localparam int RANDOM_ITEMS = 1400;
	// Hard cycle limit, above the slowest legal run: every command waiting the longest
	// drawn gap at the source, every word stalled the longest at the sink, and a reseed
	// or a refill in between.
	localparam int CYCLE_LIMIT  = 1000000;
	// Quiet time after the last word. It covers a trailing reseed, which gives no word.
	localparam int DRAIN_CYCLES = 64;
	// Mismatch lines printed before the rest are only counted.
	localparam int PRINT_LIMIT  = 30;

	// The scoreboard holds its own copy of the generator state. Each accepted draw
	// produces the expected tempered word right away, and the words that come out of
	// the block are compared in order against that queue.
	class tt800_scoreboard;
		logic [WORD_W-1:0] words [STATE_WORDS];
		int unsigned       pos;
		logic [WORD_W-1:0] expected_words [$];
		int unsigned       errors;
		int unsigned       draws;
		int unsigned       reseeds;
		int unsigned       refills;
		int unsigned       compared;

		function new();
			foreach (words[i]) begin
				words[i] = RESET_TABLE[i];
			end
			pos      = 0;
			errors   = 0;
			draws    = 0;
			reseeds  = 0;
			refills  = 0;
			compared = 0;
		endfunction

		task report_mismatch(input string msg);
			if (errors < PRINT_LIMIT) begin
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			end
			errors++;
		endtask

		// Output scrambling: two masked left shifts, then fold the upper half down.
		function logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] w);
			logic [WORD_W-1:0] y;
			y = w;
			y = y ^ ({y[24:0], 7'b0} & TEMPER_B);
			y = y ^ ({y[16:0], 15'b0} & TEMPER_C);
			y = y ^ {16'b0, y[31:16]};
			return y;
		endfunction

		// Regenerate all words in place. The update runs in index order, so the last
		// seven words already combine with freshly regenerated partners.
		function void refill();
			logic [WORD_W-1:0] w;
			for (int i = 0; i < STATE_WORDS; i++) begin
				w = words[i];
				words[i] = words[(i + TAP_OFFSET) % STATE_WORDS] ^ {1'b0, w[31:1]}
					^ (w[0] ? MAG_VECTOR : {WORD_W{1'b0}});
			end
			refills++;
		endfunction

		// Called once per accepted command transfer.
		function void note_command(input logic c, input logic [WORD_W-1:0] s);
			if (c == CMD_SEED) begin
				// The read position is deliberately left where it was.
				words[0] = s;
				for (int i = 1; i < STATE_WORDS; i++) begin
					words[i] = words[i-1] * SEED_MULT;
				end
				reseeds++;
			end else begin
				if (pos >= STATE_WORDS) begin
					refill();
					pos = 0;
				end
				expected_words = {expected_words, tempered(words[pos])};
				pos++;
				draws++;
			end
		endfunction

		// Called once per accepted word transfer.
		task check_word(input logic [WORD_W-1:0] w);
			logic [WORD_W-1:0] want;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("word %h arrived with no draw outstanding", w));
			end else begin
				want = expected_words.pop_front();
				compared++;
				if (w !== want) begin
					report_mismatch($sformatf("random_word %h, expected %h (word %0d)",
						w, want, compared));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	tt800_cmd_if  req_ch ();
	tt800_word_if rsp_ch ();

	tt800_random_generator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tt800_scoreboard sb = new();

	// Each side alternates between stretches where it never idles and stretches where
	// every transfer is preceded by a random wait.
	bit src_calm;
	bit snk_calm;

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = ~clk;
		end
	end

	function automatic int unsigned pick_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// Seed values lean toward the all-zero and all-one words now and then.
	function automatic logic [WORD_W-1:0] pick_seed();
		case ($urandom_range(0, 15))
			0: begin
				return {WORD_W{1'b0}};
			end
			1: begin
				return {WORD_W{1'b1}};
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// Offer one command and hold it until the block takes it. Valid is only lowered
	// when a wait is drawn, so back-to-back commands keep it high without a glitch.
	task automatic send_command(input logic c, input logic [WORD_W-1:0] s);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0) begin
			src_calm = ~src_calm;
		end
		gap = pick_gap(src_calm);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.seed_value <= s;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		sb.note_command(c, s);
	endtask

	// Sink side: before each word it may hold ready low for a while. Ready stays high
	// across back-to-back words when no stall is drawn.
	initial begin : word_sink
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				snk_calm = ~snk_calm;
			end
			stall = pick_gap(snk_calm);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!rsp_ch.valid);
		end
	end

	// Every word transfer is checked at the edge where it happens.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_word(rsp_ch.random_word);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d words outstanding.",
			cycles, sb.expected_words.size());
		$display("tt800_random_generator test failed");
		$finish;
	end

	initial begin : stimulus
		logic c;
		logic [WORD_W-1:0] s;

		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= CMD_DRAW;
		req_ch.seed_value <= {WORD_W{1'b0}};
		arst_n            <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. The first draws read the built-in table; the seed field of
		// a draw carries extreme values that the block must ignore.
		send_command(CMD_DRAW, {WORD_W{1'b0}});
		send_command(CMD_DRAW, {WORD_W{1'b1}});
		send_command(CMD_DRAW, 32'h5555_5555);
		// Reseed mid-stream: the position is kept, so the next draw continues at word 3
		// of the new state. A zero seed makes every word zero.
		send_command(CMD_SEED, {WORD_W{1'b0}});
		send_command(CMD_DRAW, 32'haaaa_aaaa);
		send_command(CMD_DRAW, {WORD_W{1'b0}});
		send_command(CMD_SEED, {WORD_W{1'b1}});
		send_command(CMD_DRAW, {WORD_W{1'b0}});
		send_command(CMD_DRAW, {WORD_W{1'b1}});
		send_command(CMD_SEED, 32'h0000_0001);
		send_command(CMD_DRAW, {WORD_W{1'b0}});
		send_command(CMD_SEED, 32'h8000_0000);
		send_command(CMD_DRAW, {WORD_W{1'b0}});
		// Back-to-back reseeds: only the second one may be visible.
		send_command(CMD_SEED, 32'ha5a5_a5a5);
		send_command(CMD_SEED, 32'h5a5a_5a5a);
		send_command(CMD_DRAW, {WORD_W{1'b0}});
		send_command(CMD_DRAW, {WORD_W{1'b0}});
		send_command(CMD_SEED, 32'h1234_5678);
		send_command(CMD_DRAW, {WORD_W{1'b1}});

		// Random part: mostly draws so the state is refilled many times, with reseeds
		// mixed in. When the whole state has just been used up, a reseed is made much
		// more likely, so it lands right before a pending refill.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (sb.pos == STATE_WORDS && $urandom_range(0, 1) == 1) begin
				c = CMD_SEED;
			end else if ($urandom_range(0, 99) < 12) begin
				c = CMD_SEED;
			end else begin
				c = CMD_DRAW;
			end
			s = pick_seed();
			send_command(c, s);
		end
		req_ch.valid <= 1'b0;

		// Let the outstanding words come out, then give the block time to finish a
		// trailing reseed before judging the run.
		while (sb.expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d draws and %0d reseeds, with %0d full state refills.",
			sb.draws, sb.reseeds, sb.refills);
		$display("%0d words compared, %0d mismatches.", sb.compared, sb.errors);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("tt800_random_generator test passed");
		end else begin
			$display("tt800_random_generator test failed");
		end
		$finish;
	end

endmodule
